// File: src/nnfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnfs_pkg
// Shared types and constants for the nearest-neighbour frame scaler.
// ----------------------------------------------------------------------------
package nnfs_pkg;

  localparam int SOURCE_WIDTH  = 640;
  localparam int SOURCE_HEIGHT = 400;
  localparam int FRAME_ENTRIES = SOURCE_WIDTH * SOURCE_HEIGHT;

  localparam int NNFS_ADDR_W   = $clog2(FRAME_ENTRIES);
  localparam int NNFS_PIXEL_W  = 24;
  localparam int NNFS_COORD_W  = 12;
  localparam int NNFS_OFFSET_W = 26;

  // Scaled coordinates stay below 4096 * 640, quotients below 1024.
  localparam int NNFS_DIVIDEND_W = 22;
  localparam int NNFS_QUOT_W     = 10;

  localparam logic [7:0] FOURTH_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    CFG_DISPLAY_PRESENT = 3'd0,
    CFG_NATIVE_WIDTH    = 3'd1,
    CFG_NATIVE_HEIGHT   = 3'd2,
    CFG_LINE_STRIDE     = 3'd3,
    CFG_BYTES_PER_PIXEL = 3'd4,
    CFG_CHANNEL_ORDER   = 3'd5
  } cfg_index_t;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_RENDER = 1'b1
  } req_kind_t;

  localparam logic [1:0] ORDER_BGR = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [17:0] source_index;
    logic [23:0] source_pixel;
    logic [11:0] out_column;
    logic [11:0] out_row;
  } req_t;

  typedef struct packed {
    logic        drawn;
    logic [25:0] byte_offset;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [2:0]  byte_count;
  } result_t;

endpackage : nnfs_pkg
`default_nettype wire

// File: src/nnfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnfs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nnfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : nnfs_ram
`default_nettype wire

// File: src/nnfs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnfs_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnfs_div
  import nnfs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [NNFS_DIVIDEND_W-1:0] dividend,
  input  wire logic [NNFS_COORD_W-1:0]    divisor,
  output logic                            done,
  output logic      [NNFS_QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(NNFS_QUOT_W + 1);

  logic                       running;
  logic [CNT_W-1:0]           count;
  logic [NNFS_DIVIDEND_W-1:0] rem;
  logic [NNFS_DIVIDEND_W-1:0] shifted;
  logic                       fits;

  assign fits = (rem >= shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(NNFS_QUOT_W);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      shifted  <= NNFS_DIVIDEND_W'(divisor) << (NNFS_QUOT_W - 1);
      quotient <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - shifted;
      end
      shifted  <= shifted >> 1;
      quotient <= {quotient[NNFS_QUOT_W-2:0], fits};
    end
  end

endmodule : nnfs_div
`default_nettype wire

// File: src/nearest_neighbour_frame_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_frame_scaler
// Scales a stored 640x400 source frame to native coordinates.
// ----------------------------------------------------------------------------
// A write request leaves the block ready again at once; its all-zero result
// appears in the next cycle. A render request with a usable geometry and
// coordinate runs the two coordinate divisions side by side, one quotient
// bit a cycle, then forms the source address and issues the frame memory
// read in S_ADDR and registers the result from the read data in S_READ.
// Other render requests answer in the next cycle with drawn low.
// Results are strobed for one cycle and cannot be held off, and busy is high
// while a render is in flight.
module nearest_neighbour_frame_scaler
  import nnfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_ADDR = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic                    display_present;
  logic [NNFS_COORD_W-1:0] native_width;
  logic [NNFS_COORD_W-1:0] native_height;
  logic [NNFS_COORD_W-1:0] line_stride;
  logic [2:0]              bytes_per_pixel;
  logic [1:0]              channel_order;

  logic                          accept;
  logic                          geom_ok;
  logic                          in_range;
  logic                          render_go;
  logic                          ram_we;
  logic [NNFS_DIVIDEND_W-1:0]    col_scaled;
  logic [NNFS_DIVIDEND_W-1:0]    row_scaled;
  logic                          x_done;
  logic                          y_done;
  logic [NNFS_QUOT_W-1:0]        x_quot;
  logic [NNFS_QUOT_W-1:0]        y_quot;
  logic [NNFS_QUOT_W-1:0]        sx;
  logic [NNFS_QUOT_W-1:0]        sy;
  logic [NNFS_ADDR_W-1:0]        src_addr;
  logic [NNFS_PIXEL_W-1:0]       ram_rdata;
  logic [NNFS_COORD_W-1:0]       col;
  logic [2*NNFS_COORD_W-1:0]     row_stride;
  logic [2*NNFS_COORD_W:0]       linear;
  logic [NNFS_OFFSET_W-1:0]      offset;
  logic [7:0]                    ch [4];
  result_t                       drawn_result;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_present <= 1'b0;
      native_width    <= '0;
      native_height   <= '0;
      line_stride     <= '0;
      bytes_per_pixel <= '0;
      channel_order   <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DISPLAY_PRESENT: display_present <= cfg_data[0];
        CFG_NATIVE_WIDTH:    native_width    <= cfg_data;
        CFG_NATIVE_HEIGHT:   native_height   <= cfg_data;
        CFG_LINE_STRIDE:     line_stride     <= cfg_data;
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        CFG_CHANNEL_ORDER:   channel_order   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign geom_ok = display_present && (native_width != '0) && (native_height != '0)
                && (line_stride >= native_width)
                && (bytes_per_pixel != 3'd0) && (bytes_per_pixel <= 3'd4);
  assign in_range  = (req.out_column < native_width) && (req.out_row < native_height);
  assign render_go = accept && (req.req_type == REQ_RENDER) && geom_ok && in_range;
  assign ram_we    = accept && (req.req_type == REQ_WRITE)
                  && (32'(req.source_index) < FRAME_ENTRIES);

  assign col_scaled = NNFS_DIVIDEND_W'(32'(req.out_column) * SOURCE_WIDTH);
  assign row_scaled = NNFS_DIVIDEND_W'(32'(req.out_row) * SOURCE_HEIGHT);

  nnfs_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (render_go),
    .dividend (col_scaled),
    .divisor  (native_width),
    .done     (x_done),
    .quotient (x_quot)
  );

  nnfs_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (render_go),
    .dividend (row_scaled),
    .divisor  (native_height),
    .done     (y_done),
    .quotient (y_quot)
  );

  assign sx = (32'(x_quot) >= SOURCE_WIDTH)  ? NNFS_QUOT_W'(SOURCE_WIDTH - 1)  : x_quot;
  assign sy = (32'(y_quot) >= SOURCE_HEIGHT) ? NNFS_QUOT_W'(SOURCE_HEIGHT - 1) : y_quot;
  assign src_addr = NNFS_ADDR_W'(32'(sy) * SOURCE_WIDTH + 32'(sx));

  nnfs_ram #(
    .WIDTH (NNFS_PIXEL_W),
    .DEPTH (FRAME_ENTRIES)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.source_index),
    .wdata (req.source_pixel),
    .re    (state == S_ADDR),
    .raddr (src_addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (render_go) state_next = S_DIV;
      S_DIV:  if (x_done) state_next = S_ADDR;
      S_ADDR: state_next = S_READ;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Native byte offset
  assign linear = (2*NNFS_COORD_W+1)'(row_stride) + (2*NNFS_COORD_W+1)'(col);

  always_ff @(posedge clk) begin
    if (render_go) begin
      col        <= req.out_column;
      row_stride <= (2*NNFS_COORD_W)'(req.out_row) * (2*NNFS_COORD_W)'(line_stride);
    end
    if (state == S_ADDR) begin
      offset <= NNFS_OFFSET_W'(32'(linear) * 32'(bytes_per_pixel));
    end
  end

  // Channel ordering and drawn result
  always_comb begin
    if (channel_order == ORDER_BGR) begin
      ch[0] = ram_rdata[7:0];
      ch[2] = ram_rdata[23:16];
    end else begin
      ch[0] = ram_rdata[23:16];
      ch[2] = ram_rdata[7:0];
    end
    ch[1] = ram_rdata[15:8];
    ch[3] = FOURTH_BYTE;

    drawn_result             = '0;
    drawn_result.drawn       = 1'b1;
    drawn_result.byte_offset = offset;
    drawn_result.byte_zero   = (bytes_per_pixel > 3'd0) ? ch[0] : 8'd0;
    drawn_result.byte_one    = (bytes_per_pixel > 3'd1) ? ch[1] : 8'd0;
    drawn_result.byte_two    = (bytes_per_pixel > 3'd2) ? ch[2] : 8'd0;
    drawn_result.byte_three  = (bytes_per_pixel > 3'd3) ? ch[3] : 8'd0;
    drawn_result.byte_count  = bytes_per_pixel;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (accept && !render_go) || (state == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      result <= drawn_result;
    end else if (accept && !render_go) begin
      result <= '0;
    end
  end

  // Checks
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done)
    else $error("coordinate dividers out of step");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    x_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_read_to_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> result_valid && result.drawn)
    else $error("memory read did not produce a drawn result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.drawn |-> $past(state == S_READ))
    else $error("drawn result without a frame read");

  a_no_write_in_flight: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE && !render_go)
    else $error("frame write during a render");

endmodule : nearest_neighbour_frame_scaler
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_neighbour_frame_scaler. A scoreboard keeps
// its own copy of the source frame and the display registers, predicts the
// result of every accepted request beat and compares each strobed result
// with the oldest prediction. Directed requests come first, then random
// phases under changing display settings, with random idle cycles.
// ----------------------------------------------------------------------------
module testbench;
  import nnfs_pkg::*;

  localparam logic [1:0] ORDER_AT_RESET = 2'd1;
  localparam int         TOTAL_ITEMS    = 1350;
  localparam int         QUIET_LIMIT    = 2000;

  class scaler_scoreboard;
    bit [23:0]  frame [FRAME_ENTRIES];
    bit         written [FRAME_ENTRIES];
    bit         display_on;
    bit [11:0]  width;
    bit [11:0]  height;
    bit [11:0]  stride;
    bit [2:0]   bpp;
    bit [1:0]   order;
    result_t    expected_pixels [$];
    int         errors;

    function new();
      order = ORDER_AT_RESET;
    endfunction

    function void set_register(cfg_index_t idx, bit [11:0] data);
      case (idx)
        CFG_DISPLAY_PRESENT: display_on = data[0];
        CFG_NATIVE_WIDTH:    width = data;
        CFG_NATIVE_HEIGHT:   height = data;
        CFG_LINE_STRIDE:     stride = data;
        CFG_BYTES_PER_PIXEL: bpp = data[2:0];
        CFG_CHANNEL_ORDER:   order = data[1:0];
        default: ;
      endcase
    endfunction

    function bit reads_entry(req_t r, output int unsigned idx);
      int unsigned sx;
      int unsigned sy;
      idx = 0;
      if (r.req_type != REQ_RENDER || !display_on) return 0;
      if (width == 0 || height == 0 || stride < width) return 0;
      if (bpp == 0 || bpp > 4) return 0;
      if (r.out_column >= width || r.out_row >= height) return 0;
      sx = r.out_column * SOURCE_WIDTH / width;
      sy = r.out_row * SOURCE_HEIGHT / height;
      if (sx >= SOURCE_WIDTH) sx = SOURCE_WIDTH - 1;
      if (sy >= SOURCE_HEIGHT) sy = SOURCE_HEIGHT - 1;
      idx = sy * SOURCE_WIDTH + sx;
      return 1;
    endfunction

    function result_t scale_pixel(req_t r);
      result_t     p;
      int unsigned idx;
      bit [23:0]   px;
      bit [7:0]    first_byte;
      bit [7:0]    third_byte;
      bit [63:0]   off;
      bit [63:0]   row_w;
      bit [63:0]   col_w;
      p = '0;
      if (r.req_type == REQ_WRITE) begin
        if (r.source_index < FRAME_ENTRIES) begin
          frame[r.source_index] = r.source_pixel;
          written[r.source_index] = 1'b1;
        end
        return p;
      end
      if (!reads_entry(r, idx)) return p;
      px = frame[idx];
      if (order == ORDER_BGR) begin
        first_byte = px[7:0];
        third_byte = px[23:16];
      end else begin
        first_byte = px[23:16];
        third_byte = px[7:0];
      end
      row_w = 64'(r.out_row);
      col_w = 64'(r.out_column);
      off = row_w * 64'(stride) * 64'(bpp) + col_w * 64'(bpp);
      p.drawn       = 1'b1;
      p.byte_offset = off[25:0];
      p.byte_zero   = first_byte;
      p.byte_one    = (bpp > 1) ? px[15:8] : 8'h00;
      p.byte_two    = (bpp > 2) ? third_byte : 8'h00;
      p.byte_three  = (bpp > 3) ? FOURTH_BYTE : 8'h00;
      p.byte_count  = bpp;
      return p;
    endfunction

    function void note_request(req_t r);
      expected_pixels.push_back(scale_pixel(r));
    endfunction

    function void compare_field(string field, logic [25:0] want, logic [25:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result expected none actual 0x%0h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("drawn", 26'(want.drawn), 26'(got.drawn));
      compare_field("byte_offset", want.byte_offset, got.byte_offset);
      compare_field("byte_zero", 26'(want.byte_zero), 26'(got.byte_zero));
      compare_field("byte_one", 26'(want.byte_one), 26'(got.byte_one));
      compare_field("byte_two", 26'(want.byte_two), 26'(got.byte_two));
      compare_field("byte_three", 26'(want.byte_three), 26'(got.byte_three));
      compare_field("byte_count", 26'(want.byte_count), 26'(got.byte_count));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  scaler_scoreboard sb;
  int              items_sent;
  int              quiet_cycles;
  bit              gaps_on;
  int              cur_width;
  int              cur_height;

  nearest_neighbour_frame_scaler u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_pixel(result);
      if (start && !busy) sb.note_request(req);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index_t'(cfg_index), cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t random_request();
    req_t        r;
    logic [95:0] noise_bits;
    noise_bits = {$urandom, $urandom, $urandom};
    r = noise_bits[$bits(req_t)-1:0];
    return r;
  endfunction

  task automatic send(input req_t r);
    if (gaps_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic store(input int unsigned idx, input bit [23:0] pixel);
    req_t r;
    r = random_request();
    r.req_type     = REQ_WRITE;
    r.source_index = 18'(idx);
    r.source_pixel = pixel;
    send(r);
  endtask

  // A render never reads a frame entry that has not been written: the entry
  // it maps to is stored first, and always so when a fresh value is wanted.
  task automatic render(input bit [11:0] col, input bit [11:0] row, input bit fresh);
    req_t        r;
    int unsigned idx;
    r = random_request();
    r.req_type   = REQ_RENDER;
    r.out_column = col;
    r.out_row    = row;
    if (sb.reads_entry(r, idx) && (fresh || !sb.written[idx])) store(idx, 24'($urandom));
    send(r);
  endtask

  task automatic configure(input bit disp, input int width, input int height,
                           input int stride, input int bpp, input int order);
    cfg_index_t ri;
    bit [11:0]  noise;
    bit [11:0]  data;
    wait_idle();
    cur_width  = width;
    cur_height = height;
    ri = ri.first();
    cfg_valid <= 1'b1;
    do begin
      noise = 12'($urandom);
      case (ri)
        CFG_DISPLAY_PRESENT: data = {noise[11:1], disp};
        CFG_NATIVE_WIDTH:    data = 12'(width);
        CFG_NATIVE_HEIGHT:   data = 12'(height);
        CFG_LINE_STRIDE:     data = 12'(stride);
        CFG_BYTES_PER_PIXEL: data = {noise[11:3], 3'(bpp)};
        default:             data = {noise[11:2], 2'(order)};
      endcase
      cfg_index <= ri;
      cfg_data  <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      ri = ri.next();
    end while (ri != ri.first());
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return $urandom_range(1, 16);
    if (roll < 40) return $urandom_range(1) ? 4095 : 1;
    if (roll < 60) return $urandom_range(100, 1000);
    return $urandom_range(1, 4095);
  endfunction

  function automatic bit [11:0] pick_coord(input int limit);
    bit [11:0] v;
    v = 12'($urandom);
    if (limit > 0 && $urandom_range(99) < 80) v = 12'($urandom_range(0, limit - 1));
    return v;
  endfunction

  task automatic random_configure();
    int kind;
    int width;
    int height;
    int stride;
    int bpp;
    int pick;
    kind   = $urandom_range(11);
    width  = pick_dim();
    height = pick_dim();
    stride = $urandom_range(width, 4095);
    bpp    = $urandom_range(1, 4);
    case (kind)
      1: begin
        pick = $urandom_range(3);
        bpp  = (pick == 0) ? 0 : pick + 4;
      end
      2: begin
        if (width < 2) width = 2;
        stride = $urandom_range(0, width - 1);
      end
      3: begin
        if ($urandom_range(1)) width = 0;
        else height = 0;
      end
      default: ;
    endcase
    configure(kind != 0, width, height, stride, bpp, $urandom_range(3));
  endtask

  initial begin
    int phase;
    int roll;
    sb         = new();
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    render(12'd0, 12'd0, 1'b0);
    store(0, 24'hFFFFFF);
    store(1, 24'h000000);
    store(FRAME_ENTRIES - 1, 24'h5AA5C3);
    store(FRAME_ENTRIES, 24'hABCDEF);
    store(18'h3FFFF, 24'h123456);

    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 4, 0);
    render(12'd0, 12'd0, 1'b0);
    render(12'd639, 12'd399, 1'b0);
    render(12'd640, 12'd0, 1'b0);
    render(12'd0, 12'd400, 1'b0);
    render(12'd4095, 12'd4095, 1'b0);

    configure(1'b1, 4095, 4095, 4095, 4, ORDER_BGR);
    render(12'd4094, 12'd4094, 1'b0);
    render(12'd4095, 12'd0, 1'b0);
    configure(1'b1, 1, 1, 1, 1, ORDER_BGR);
    render(12'd0, 12'd0, 1'b0);
    render(12'd1, 12'd0, 1'b0);
    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 2, 3);
    render(12'd1, 12'd1, 1'b0);
    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 3, 0);
    render(12'd0, 12'd0, 1'b0);

    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH - 1, 4, 0);
    render(12'd0, 12'd0, 1'b0);
    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 0, 0);
    render(12'd0, 12'd0, 1'b0);
    configure(1'b1, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 5, 0);
    render(12'd0, 12'd0, 1'b0);
    configure(1'b1, 0, SOURCE_HEIGHT, SOURCE_WIDTH, 4, 0);
    render(12'd0, 12'd0, 1'b0);
    configure(1'b1, SOURCE_WIDTH, 0, SOURCE_WIDTH, 4, 0);
    render(12'd0, 12'd0, 1'b0);
    configure(1'b0, SOURCE_WIDTH, SOURCE_HEIGHT, SOURCE_WIDTH, 4, 0);
    render(12'd0, 12'd0, 1'b0);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      random_configure();
      gaps_on = (phase != 2);
      repeat ($urandom_range(60, 140)) begin
        if (items_sent >= TOTAL_ITEMS) break;
        roll = $urandom_range(99);
        if (roll < 27)
          store($urandom_range(0, FRAME_ENTRIES - 1), 24'($urandom));
        else if (roll < 30)
          store($urandom_range(FRAME_ENTRIES, 18'h3FFFF), 24'($urandom));
        else
          render(pick_coord(cur_width), pick_coord(cur_height), roll < 45);
        if ($urandom_range(99) < 2) wait_idle();
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/nnfs_pkg.sv
src/nnfs_ram.sv
src/nnfs_div.sv
src/nearest_neighbour_frame_scaler.sv
verif/testbench.sv
